FILE: rtl/core/text_terminal_char_engine_macros.svh
// Assertion helpers for the engine's RTL; the controller (tte_ctrl) includes them.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef TEXT_TERMINAL_CHAR_ENGINE_MACROS_SVH
`define TEXT_TERMINAL_CHAR_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TTE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/tte_pkg.sv
package tte_pkg;

	// Field widths
	localparam int CMD_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int INDEX_W   = 11;
	localparam int CELL_W    = 16;
	localparam int COLOR_W   = 4;
	localparam int CFG_IDX_W = 1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PRINT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	// Reset values
	localparam logic [CELL_W-1:0]  RESET_CELL = 16'h0720;
	localparam logic [COLOR_W-1:0] FG_RESET   = 4'd7;
	localparam logic [COLOR_W-1:0] BG_RESET   = 4'd0;

	// Controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic exec_print;
		logic home;
		logic rd_issue;
		logic start_sweep;
		logic copy_step;
		logic fill_step;
		logic fill_reset;
		logic out_load;
	} tte_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic [CMD_W-1:0] item_cmd;
		logic             need_scroll;
		logic             copy_end;
		logic             ptr_last;
		logic             out_free;
	} tte_sts_t;

endpackage

FILE: rtl/core/tte_if.sv
// Input item channel
interface tte_in_if;
	logic                              valid;
	logic                              ready;
	logic [tte_pkg::CMD_W-1:0]         cmd;
	logic [tte_pkg::CHAR_W-1:0]        ch;
	logic [tte_pkg::INDEX_W-1:0]       cell_index;

	modport source (output valid, output cmd, output ch, output cell_index, input ready);
	modport sink (input valid, input cmd, input ch, input cell_index, output ready);
endinterface

// Result channel
interface tte_out_if;
	logic                              valid;
	logic                              ready;
	logic [tte_pkg::INDEX_W-1:0]       cursor_index;
	logic [tte_pkg::CELL_W-1:0]        cell_value;

	modport source (output valid, output cursor_index, output cell_value, input ready);
	modport sink (input valid, input cursor_index, input cell_value, output ready);
endinterface

FILE: rtl/core/tte_ram.sv
module tte_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word; read data holds when idle
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/tte_ctrl.sv
module tte_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  tte_pkg::tte_sts_t sts,
	output tte_pkg::tte_ctl_t ctl
);

	`include "text_terminal_char_engine_macros.svh"

	localparam logic [2:0] ST_RESET_FILL = 3'd0;
	localparam logic [2:0] ST_IDLE       = 3'd1;
	localparam logic [2:0] ST_EXEC       = 3'd2;
	localparam logic [2:0] ST_SCROLL     = 3'd3;
	localparam logic [2:0] ST_FILL       = 3'd4;
	localparam logic [2:0] ST_DONE       = 3'd5;

	logic [2:0] st_q;
	logic [2:0] st_nxt;

	// Fill the store after reset, then sequence one item: execute, sweep the store if needed, post the result
	always_comb begin
		ctl       = '0;
		st_nxt    = st_q;
		req_ready = 1'b0;
		case (st_q)
			ST_RESET_FILL: begin
				ctl.fill_step  = 1'b1;
				ctl.fill_reset = 1'b1;
				if (sts.ptr_last)
					st_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load_item = 1'b1;
					st_nxt        = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (sts.item_cmd)
					tte_pkg::CMD_PRINT: begin
						ctl.exec_print = 1'b1;
						if (sts.need_scroll) begin
							ctl.start_sweep = 1'b1;
							st_nxt          = ST_SCROLL;
						end else begin
							st_nxt = ST_DONE;
						end
					end
					tte_pkg::CMD_CLEAR: begin
						ctl.home        = 1'b1;
						ctl.start_sweep = 1'b1;
						st_nxt          = ST_FILL;
					end
					tte_pkg::CMD_READ: begin
						ctl.rd_issue = 1'b1;
						st_nxt       = ST_DONE;
					end
					default: st_nxt = ST_DONE;
				endcase
			end
			ST_SCROLL: begin
				ctl.copy_step = 1'b1;
				if (sts.copy_end)
					st_nxt = ST_FILL;
			end
			ST_FILL: begin
				ctl.fill_step = 1'b1;
				if (sts.ptr_last)
					st_nxt = ST_DONE;
			end
			ST_DONE: begin
				// Once the result word is free, post the result and take the next item in the same cycle
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					req_ready    = 1'b1;
					if (req_valid) begin
						ctl.load_item = 1'b1;
						st_nxt        = ST_EXEC;
					end else begin
						st_nxt = ST_IDLE;
					end
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_RESET_FILL;
		else
			st_q <= st_nxt;
	end

	`TTE_ASSERT_IMP(a_out_free, ctl.out_load, sts.out_free, "result word overwritten")
	`TTE_ASSERT_NXT(a_accept_exec, req_valid && req_ready, st_q == ST_EXEC, "item not executed")
	`TTE_ASSERT_NXT(a_copy_fill, (st_q == ST_SCROLL) && sts.copy_end, st_q == ST_FILL, "scroll lost")
	`TTE_ASSERT_IMP(a_one_writer, 1'b1,
		$onehot0({ctl.exec_print, ctl.copy_step, ctl.fill_step}), "store write conflict")

endmodule

FILE: rtl/core/tte_dpath.sv
module tte_dpath #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tte_pkg::tte_ctl_t                ctl,
	output tte_pkg::tte_sts_t                sts,
	input  logic [tte_pkg::CMD_W-1:0]        req_cmd,
	input  logic [tte_pkg::CHAR_W-1:0]       req_ch,
	input  logic [tte_pkg::INDEX_W-1:0]      req_cell_index,
	input  logic                             cfg_we,
	input  logic [tte_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tte_pkg::COLOR_W-1:0]      cfg_data,
	input  logic                             rsp_ready,
	output logic                             rsp_valid,
	output logic [tte_pkg::INDEX_W-1:0]      rsp_cursor_index,
	output logic [tte_pkg::CELL_W-1:0]       rsp_cell_value
);

	localparam int CELLS    = ROWS * COLUMNS;
	localparam int AW       = $clog2(CELLS);
	localparam int CW       = $clog2(COLUMNS);
	localparam int RW       = $clog2(ROWS);
	localparam int PW       = $clog2(TAB_STOP);
	localparam int NW       = $clog2(COLUMNS + TAB_STOP);
	localparam int LW       = (AW > tte_pkg::INDEX_W) ? AW : tte_pkg::INDEX_W;
	localparam int COPY_END = CELLS - COLUMNS;

	// Item and result registers
	logic [tte_pkg::CMD_W-1:0]   cmd_q;
	logic [tte_pkg::CHAR_W-1:0]  ch_q;
	logic [tte_pkg::INDEX_W-1:0] idx_q;
	logic                        rd_ok_q;
	logic                        out_vld_q;
	logic [tte_pkg::INDEX_W-1:0] out_cur_q;
	logic [tte_pkg::CELL_W-1:0]  out_cell_q;

	// Cursor, sweep pointer and colors
	logic [RW-1:0]               row_q;
	logic [CW-1:0]               col_q;
	logic [PW-1:0]               phase_q;
	logic [AW-1:0]               ptr_q;
	logic                        cp_vld_q;
	logic [AW-1:0]               cp_dst_q;
	logic [tte_pkg::COLOR_W-1:0] fg_q;
	logic [tte_pkg::COLOR_W-1:0] bg_q;

	logic                        is_nl, is_cr, is_tab, is_glyph;
	logic                        col_last, row_last, go_down;
	logic [NW-1:0]               tab_sum, tab_col;
	logic [AW-1:0]               lin;
	logic [LW-1:0]               lin_ext, idx_ext;
	logic                        in_range;
	logic [tte_pkg::CELL_W-1:0]  blank;
	logic                        copy_end, ptr_last;
	logic                        ram_we, ram_re;
	logic [AW-1:0]               ram_waddr, ram_raddr;
	logic [tte_pkg::CELL_W-1:0]  ram_wdata, ram_rdata;

	// Decode the byte and work out the cursor move
	assign is_nl    = (ch_q == tte_pkg::CHAR_NL);
	assign is_cr    = (ch_q == tte_pkg::CHAR_CR);
	assign is_tab   = (ch_q == tte_pkg::CHAR_TAB);
	assign is_glyph = !(is_nl || is_cr || is_tab);
	assign col_last = (col_q == CW'(COLUMNS - 1));
	assign row_last = (row_q == RW'(ROWS - 1));
	assign go_down  = is_nl || (is_glyph && col_last);

	// Next tab stop from the column phase; step back one stop past the row end
	assign tab_sum = NW'(col_q) + NW'(TAB_STOP) - NW'(phase_q);
	assign tab_col = (tab_sum >= NW'(COLUMNS)) ? (tab_sum - NW'(TAB_STOP)) : tab_sum;

	assign lin      = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign lin_ext  = LW'(lin);
	assign idx_ext  = LW'(idx_q);
	assign in_range = ({1'b0, idx_ext} < (LW + 1)'(CELLS));
	assign blank    = {bg_q, fg_q, tte_pkg::CHAR_SPACE};
	assign copy_end = (ptr_q == AW'(COPY_END));
	assign ptr_last = (ptr_q == AW'(CELLS - 1));

	assign sts.item_cmd    = cmd_q;
	assign sts.need_scroll = go_down && row_last;
	assign sts.copy_end    = copy_end;
	assign sts.ptr_last    = ptr_last;
	assign sts.out_free    = !out_vld_q || rsp_ready;

	// Steer the store ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = lin;
		ram_wdata = {bg_q, fg_q, ch_q};
		ram_re    = 1'b0;
		ram_raddr = idx_ext[AW-1:0];
		if (ctl.exec_print && is_glyph)
			ram_we = 1'b1;
		if (ctl.copy_step && cp_vld_q) begin
			ram_we    = 1'b1;
			ram_waddr = cp_dst_q;
			ram_wdata = ram_rdata;
		end
		if (ctl.fill_step) begin
			ram_we    = 1'b1;
			ram_waddr = ptr_q;
			ram_wdata = ctl.fill_reset ? tte_pkg::RESET_CELL : blank;
		end
		if (ctl.rd_issue)
			ram_re = 1'b1;
		if (ctl.copy_step && !copy_end) begin
			ram_re    = 1'b1;
			ram_raddr = ptr_q + AW'(COLUMNS);
		end
	end

	tte_ram #(
		.WIDTH (tte_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control state: colors, cursor, sweep pointer, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q      <= tte_pkg::FG_RESET;
			bg_q      <= tte_pkg::BG_RESET;
			row_q     <= '0;
			col_q     <= '0;
			phase_q   <= '0;
			ptr_q     <= '0;
			cp_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tte_pkg::CFG_FG: fg_q <= cfg_data;
					tte_pkg::CFG_BG: bg_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.home) begin
				row_q   <= '0;
				col_q   <= '0;
				phase_q <= '0;
			end else if (ctl.exec_print) begin
				if (go_down && !row_last)
					row_q <= row_q + RW'(1);
				if (is_glyph)
					col_q <= col_last ? '0 : col_q + CW'(1);
				else if (is_tab)
					col_q <= tab_col[CW-1:0];
				else
					col_q <= '0;
				if (is_glyph && !col_last)
					phase_q <= (phase_q == PW'(TAB_STOP - 1)) ? '0 : phase_q + PW'(1);
				else
					phase_q <= '0;
			end
			// Advance the sweep; hold at the copy end so the fill starts there
			if (ctl.start_sweep)
				ptr_q <= '0;
			else if ((ctl.copy_step && !copy_end) || (ctl.fill_step && !ptr_last))
				ptr_q <= ptr_q + AW'(1);
			cp_vld_q <= ctl.copy_step && !copy_end;
			if (ctl.out_load)
				out_vld_q <= 1'b1;
			else if (rsp_ready)
				out_vld_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cp_dst_q <= ptr_q;
		if (ctl.load_item) begin
			cmd_q <= req_cmd;
			ch_q  <= req_ch;
			idx_q <= req_cell_index;
		end
		if (ctl.rd_issue)
			rd_ok_q <= in_range;
		if (ctl.out_load) begin
			out_cur_q  <= lin_ext[tte_pkg::INDEX_W-1:0];
			out_cell_q <= ((cmd_q == tte_pkg::CMD_READ) && rd_ok_q) ? ram_rdata : '0;
		end
	end

	assign rsp_valid        = out_vld_q;
	assign rsp_cursor_index = out_cur_q;
	assign rsp_cell_value   = out_cell_q;

endmodule

FILE: rtl/core/text_terminal_char_engine.sv
// A non-scrolling print, read or unused command runs in the execute state and posts its
// result from the done state when the result word is free, taking the next item too.
// A scroll copies each row up one, then blanks the last row in the current colors.
// A clear homes the cursor and blanks every cell, one cell written per cycle.
// After reset all ROWS*COLUMNS cells (2000 by default) are swept to 0x0720
// with ready low; colors reset to 7 on 0, cursor homes, color writes are taken at once.
module text_terminal_char_engine #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tte_in_if.sink                        req,
	tte_out_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [tte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tte_pkg::COLOR_W-1:0]   cfg_data
);

	tte_pkg::tte_ctl_t ctl;
	tte_pkg::tte_sts_t sts;

	tte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	tte_dpath #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.req_cmd          (req.cmd),
		.req_ch           (req.ch),
		.req_cell_index   (req.cell_index),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp.valid),
		.rsp_cursor_index (rsp.cursor_index),
		.rsp_cell_value   (rsp.cell_value)
	);

endmodule

FILE: tb/text_terminal_char_engine_tb.sv
`timescale 1ns / 1ps

module text_terminal_char_engine_tb;

	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int TAB = 4;
	localparam int CELLS = ROWS * COLS;
	localparam int INDEX_SPAN = 1 << tte_pkg::INDEX_W;
	// a scroll or clear sweeps the whole store, so allow for one after the last word
	localparam int SETTLE_CYCLES = CELLS + 16;
	// every item at worst: longest gap, longest stall, a full scroll; then four times over
	localparam int CYCLE_LIMIT = 16_000_000;

	// command code with no function in the block
	localparam logic [tte_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [tte_pkg::CMD_W-1:0]   cmd;
		logic [tte_pkg::CHAR_W-1:0]  ch;
		logic [tte_pkg::INDEX_W-1:0] cell_index;
	} term_item_t;

	typedef struct packed {
		logic [tte_pkg::INDEX_W-1:0] cursor_index;
		logic [tte_pkg::CELL_W-1:0]  cell_value;
	} term_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [tte_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tte_pkg::COLOR_W-1:0] cfg_data;

	tte_in_if req ();
	tte_out_if rsp ();

	text_terminal_char_engine #(
		.COLUMNS (COLS),
		.ROWS    (ROWS),
		.TAB_STOP(TAB)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// screen image, cursor and colors as the block should hold them
	logic [tte_pkg::CELL_W-1:0] screen_q [0:CELLS-1];
	int cur_row;
	int cur_col;
	logic [tte_pkg::COLOR_W-1:0] fg_q;
	logic [tte_pkg::COLOR_W-1:0] bg_q;

	term_result_t cursor_cell_q [$];
	int error_count = 0;
	int cycle_count = 0;
	bit idle_on = 1'b1;
	int rx_hold = 0;

	function automatic int cursor_pos();
		return cur_row * COLS + cur_col;
	endfunction

	function automatic logic [tte_pkg::CELL_W-1:0] make_cell(
			input logic [tte_pkg::CHAR_W-1:0] c);
		return {bg_q, fg_q, c};
	endfunction

	function automatic void put_char(input logic [tte_pkg::CHAR_W-1:0] c);
		int next_col;
		if (c == tte_pkg::CHAR_NL) begin
			cur_col = 0;
			cur_row++;
		end else if (c == tte_pkg::CHAR_CR) begin
			cur_col = 0;
		end else if (c == tte_pkg::CHAR_TAB) begin
			// past the row end, fall back to the last stop inside the row
			next_col = (cur_col / TAB + 1) * TAB;
			if (next_col >= COLS)
				next_col -= TAB;
			cur_col = next_col;
		end else begin
			screen_q[cursor_pos()] = make_cell(c);
			cur_col++;
			if (cur_col >= COLS) begin
				cur_col = 0;
				cur_row++;
			end
		end
		// scroll up one row and blank the last one
		if (cur_row >= ROWS) begin
			for (int i = 0; i < CELLS - COLS; i++)
				screen_q[i] = screen_q[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++)
				screen_q[i] = make_cell(tte_pkg::CHAR_SPACE);
			cur_row = ROWS - 1;
		end
	endfunction

	function automatic term_result_t emulate_terminal(input term_item_t it);
		term_result_t res;
		res.cell_value = '0;
		case (it.cmd)
			tte_pkg::CMD_PRINT: put_char(it.ch);
			tte_pkg::CMD_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_q[i] = make_cell(tte_pkg::CHAR_SPACE);
				cur_row = 0;
				cur_col = 0;
			end
			tte_pkg::CMD_READ: begin
				if (it.cell_index < CELLS)
					res.cell_value = screen_q[it.cell_index];
			end
			default: ;
		endcase
		res.cursor_index = tte_pkg::INDEX_W'(cursor_pos());
		return res;
	endfunction

	task automatic flag_error(input string msg);
		if (error_count < 10)
			$display("ERROR: %s", msg);
		error_count++;
	endtask

	// compare one result word with the oldest expectation
	task automatic check_word();
		term_result_t exp_w;
		if (cursor_cell_q.size() == 0) begin
			flag_error($sformatf("result word with nothing expected: cursor %0d cell %h",
				rsp.cursor_index, rsp.cell_value));
		end else begin
			exp_w = cursor_cell_q.pop_front();
			if (rsp.cursor_index !== exp_w.cursor_index)
				flag_error($sformatf("cursor_index expected %0d actual %0d",
					exp_w.cursor_index, rsp.cursor_index));
			if (rsp.cell_value !== exp_w.cell_value)
				flag_error($sformatf("cell_value expected %h actual %h",
					exp_w.cell_value, rsp.cell_value));
		end
	endtask

	// offer one word, after a random gap when idle_on is set, and hold it until taken
	task automatic send_word(input logic [tte_pkg::CMD_W-1:0] cmd,
			input logic [tte_pkg::CHAR_W-1:0] ch,
			input logic [tte_pkg::INDEX_W-1:0] idx);
		term_item_t it;
		int gap;
		it = '{cmd: cmd, ch: ch, cell_index: idx};
		gap = idle_on ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= it.cmd;
		req.ch <= it.ch;
		req.cell_index <= it.cell_index;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		cursor_cell_q.push_back(emulate_terminal(it));
	endtask

	task automatic put(input logic [tte_pkg::CHAR_W-1:0] c);
		send_word(tte_pkg::CMD_PRINT, c,
			tte_pkg::INDEX_W'($urandom_range(0, INDEX_SPAN - 1)));
	endtask

	task automatic read_cell(input int idx);
		send_word(tte_pkg::CMD_READ, tte_pkg::CHAR_W'($urandom_range(0, 255)),
			tte_pkg::INDEX_W'(idx));
	endtask

	// drop valid, drain all results, then let any sweep finish
	task automatic wait_idle();
		req.valid <= 1'b0;
		while (cursor_cell_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_colors(input logic [tte_pkg::COLOR_W-1:0] fg,
			input logic [tte_pkg::COLOR_W-1:0] bg);
		cfg_we <= 1'b1;
		cfg_index <= tte_pkg::CFG_FG;
		cfg_data <= fg;
		@(posedge clk);
		cfg_index <= tte_pkg::CFG_BG;
		cfg_data <= bg;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		fg_q = fg;
		bg_q = bg;
	endtask

	task automatic test_reset_reads();
		read_cell(CELLS - 1);
		read_cell(INDEX_SPAN - 1);
		send_word(CMD_UNUSED, tte_pkg::CHAR_W'($urandom_range(0, 255)),
			tte_pkg::INDEX_W'($urandom_range(0, INDEX_SPAN - 1)));
	endtask

	task automatic test_print_controls();
		put(8'h00);
		put(8'hFF);
		put(tte_pkg::CHAR_NL);
		put(8'h41);
		put(tte_pkg::CHAR_CR);
		read_cell(0);
		read_cell(1);
		read_cell(COLS);
	endtask

	// walk the tab stops to the row end, then one more
	task automatic test_tab_stop();
		repeat (COLS / TAB) put(tte_pkg::CHAR_TAB);
	endtask

	task automatic test_color_change();
		wait_idle();
		set_colors(4'hF, 4'hF);
		put(8'h42);
		read_cell(0);
		read_cell(cursor_pos() - 1);
		send_word(tte_pkg::CMD_CLEAR, tte_pkg::CHAR_W'($urandom_range(0, 255)),
			tte_pkg::INDEX_W'($urandom_range(0, INDEX_SPAN - 1)));
		read_cell(CELLS - 1);
	endtask

	// hold the result side off while words keep coming
	task automatic test_backpressure();
		idle_on = 1'b0;
		rx_hold = 400;
		repeat (40) put(tte_pkg::CHAR_W'($urandom_range(8'h21, 8'h7E)));
		idle_on = 1'b1;
	endtask

	task automatic random_traffic(input int n);
		int sent;
		int kind;
		int len;
		int idx;
		logic [tte_pkg::CMD_W-1:0] cmd;
		sent = 0;
		while (sent < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 38) begin
				// text run, control bytes now and then
				len = $urandom_range(1, 60);
				repeat (len) put(tte_pkg::CHAR_W'($urandom_range(0, 255)));
				sent += len;
			end else if (kind < 62) begin
				// reads, mostly around recent writes
				len = $urandom_range(1, 6);
				repeat (len) begin
					case ($urandom_range(0, 9))
						0: idx = $urandom_range(CELLS, INDEX_SPAN - 1);
						1, 2, 3: idx = $urandom_range(0, CELLS - 1);
						default: idx = cursor_pos() - int'($urandom_range(0, 160));
					endcase
					if (idx < 0)
						idx = 0;
					read_cell(idx);
				end
				sent += len;
			end else if (kind < 70) begin
				len = $urandom_range(1, 22);
				repeat (len) put(tte_pkg::CHAR_TAB);
				sent += len;
			end else if (kind < 77) begin
				// newline burst, sometimes long enough to scroll
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 5);
				repeat (len) put(tte_pkg::CHAR_NL);
				sent += len;
			end else if (kind < 87) begin
				len = $urandom_range(1, 8);
				repeat (len) begin
					case ($urandom_range(0, 3))
						0: put(tte_pkg::CHAR_CR);
						1: put(tte_pkg::CHAR_NL);
						2: put(tte_pkg::CHAR_TAB);
						default: put(tte_pkg::CHAR_W'($urandom_range(0, 255)));
					endcase
				end
				sent += len;
			end else if (kind < 97) begin
				// noise: any command, any fields
				cmd = tte_pkg::CMD_W'($urandom_range(0, 3));
				send_word(cmd, tte_pkg::CHAR_W'($urandom_range(0, 255)),
					tte_pkg::INDEX_W'($urandom_range(0, INDEX_SPAN - 1)));
				if (cmd != CMD_UNUSED)
					sent++;
			end else begin
				send_word(tte_pkg::CMD_CLEAR, tte_pkg::CHAR_W'($urandom_range(0, 255)),
					tte_pkg::INDEX_W'($urandom_range(0, INDEX_SPAN - 1)));
				sent++;
			end
		end
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 5; ph++) begin
			wait_idle();
			case (ph)
				0: set_colors(4'h0, 4'h0);
				1: set_colors(4'hF, 4'hF);
				default: set_colors(tte_pkg::COLOR_W'($urandom_range(0, 15)),
					tte_pkg::COLOR_W'($urandom_range(0, 15)));
			endcase
			// one phase runs with no idling on either side
			idle_on = (ph != 1);
			random_traffic(300);
		end
		idle_on = 1'b1;
	endtask

	// result side: random stalls, long hold-off on request
	initial begin
		int rx_wait;
		rx_wait = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				check_word();
				rx_wait = idle_on ? $urandom_range(0, 17) : 0;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				rsp.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// cycle limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("text_terminal_char_engine_tb: done, errors");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.cmd <= tte_pkg::CMD_PRINT;
		req.ch <= '0;
		req.cell_index <= '0;
		cfg_we <= 1'b0;
		cfg_index <= tte_pkg::CFG_FG;
		cfg_data <= '0;
		for (int i = 0; i < CELLS; i++)
			screen_q[i] = tte_pkg::RESET_CELL;
		cur_row = 0;
		cur_col = 0;
		fg_q = tte_pkg::FG_RESET;
		bg_q = tte_pkg::BG_RESET;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_reads();
		test_print_controls();
		test_tab_stop();
		test_color_change();
		test_backpressure();
		test_random_traffic();
		wait_idle();

		if (error_count == 0)
			$display("text_terminal_char_engine_tb: done, clean");
		else
			$display("text_terminal_char_engine_tb: done, errors");
		$finish;
	end

endmodule
